@@ rtl/core/float_half_converter_assert.svh @@
// Assertion macros shared by the converter RTL
`ifndef FLOAT_HALF_CONVERTER_ASSERT_SVH
`define FLOAT_HALF_CONVERTER_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define FHC_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset
`define FHC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

@@ rtl/core/fhc_pkg.sv @@
// Package with constants for the float/half converter
package fhc_pkg;
    localparam logic OP_TO_HALF  = 1'b0;
    localparam logic OP_TO_FLOAT = 1'b1;
    localparam logic [7:0] F32_EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0] F32_EXP_HALF_INF = 8'd143;
    localparam logic [7:0] HALF_BIAS_DIFF   = 8'd112;
    localparam logic [4:0] HALF_EXP_MAX     = 5'h1F;
    localparam logic [12:0] F32_ROUND_BITS  = 13'h1FFF;
endpackage

@@ rtl/core/fhc_convert.sv @@
// Combinational conversion between binary32 and binary16 patterns
module fhc_convert (
    input  logic        op,
    input  logic [31:0] operand,
    output logic [31:0] result
);
    import fhc_pkg::*;

    logic [30:0] mag;
    logic [30:0] mag_rnd;
    logic [7:0]  exp_rnd;
    logic [15:0] half;
    logic [31:0] flt;
    logic [7:0]  fexp;

    // float to half: round magnitude away from zero, then pack
    always_comb
    begin
        mag = operand[30:0];
        if (mag[12:0] != 13'd0)
            mag_rnd = {mag[30:13], F32_ROUND_BITS} + 31'd1;
        else
            mag_rnd = mag;
        exp_rnd = mag_rnd[30:23];
        if (mag[30:23] == F32_EXP_ALL_ONES || exp_rnd >= F32_EXP_HALF_INF)
            half = {operand[31], HALF_EXP_MAX, 10'd0};
        else if (exp_rnd <= HALF_BIAS_DIFF)
            half = {operand[31], 15'd0};
        else
            half = {operand[31], 5'(exp_rnd - HALF_BIAS_DIFF), mag_rnd[22:13]};
    end

    // half to float: rebias, widen mantissa
    always_comb
    begin
        fexp = (operand[14:10] == HALF_EXP_MAX) ? F32_EXP_ALL_ONES
             : {3'd0, operand[14:10]} + HALF_BIAS_DIFF;
        if (operand[14:0] == 15'd0)
            flt = {operand[15], 31'd0};
        else
            flt = {operand[15], fexp, operand[9:0], 13'd0};
    end

    assign result = (op == OP_TO_FLOAT) ? flt : {16'd0, half};
endmodule

@@ rtl/core/float_half_converter.sv @@
// Top level: registered float32/half converter
// Path: a request is captured in the input register and its result in the result register.
// Throughput: one item per cycle; busy is always low, and the receiver cannot stall.
// The conversion logic lies between the input and result registers.
// Reset (rst_n, asynchronous, active low) clears the strobe pipeline.
module float_half_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [31:0] operand,
    output logic        done,
    output logic [31:0] result
);
    import fhc_pkg::*;
    `include "float_half_converter_assert.svh"

    logic        op_reg;
    logic [31:0] operand_reg;
    logic        vld_reg;
    logic        done_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg      <= op;
            operand_reg <= operand;
        end
    end

    fhc_convert u_conv (
        .op      (op_reg),
        .operand (operand_reg),
        .result  (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `FHC_ASSERT_NEXT(a_done_follows, clk, rst_n, vld_reg, done_reg, "done missing")
    `FHC_ASSERT_NEXT(a_no_stray_done, clk, rst_n, !vld_reg, !done_reg, "stray done")
    `FHC_ASSERT_IMP(a_half_upper_zero, clk, rst_n, done_reg && !$past(op_reg), result_reg[31:16] == 16'd0, "half result upper bits set")
endmodule
